// ===== sv/w3mm_pkg.sv =====
`default_nettype none
package w3mm_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int MAX_ROWS_DEF   = 4096;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int ROWS_W     = 13;
    localparam int COLS_W     = 11;
    localparam int START_W    = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_ROWS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_MINIMUM = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_MAXIMUM = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic MODE_MEAN   = 1'b0;
    localparam logic MODE_MEDIAN = 1'b1;

    // output queue depth, power of two
    localparam int OUTQ_DEPTH = 16;

    typedef struct packed {
        logic emit0;   // window of columns 0,1,2
        logic emit1;   // right-edge window 1,2,2
        logic last;    // final result of the frame
        logic start;   // first pixel of a frame
    } w3mm_ctl_t;

endpackage
`default_nettype wire

// ===== sv/w3mm_linebuf.sv =====
`default_nettype none
module w3mm_linebuf #(
    parameter int DEPTH = w3mm_pkg::MAX_COLS_DEF,
    parameter int WIDTH = 2 * w3mm_pkg::PIXEL_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             fwd_en_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [WIDTH-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_en_reg <= 1'b0;
        end else begin
            fwd_en_reg <= wr_en;
        end
    end

    // write landing on the same edge as the read
    assign rd_data = (fwd_en_reg && fwd_addr_reg == rd_addr_reg) ? fwd_data_reg : rd_q_reg;

endmodule
`default_nettype wire

// ===== sv/w3mm_filter.sv =====
`default_nettype none
module w3mm_filter #(
    parameter int PIXEL_BITS = w3mm_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  mode,
    input  wire logic                  col_en,
    input  wire logic                  col_first,
    input  wire logic [PIXEL_BITS-1:0] col_top,
    input  wire logic [PIXEL_BITS-1:0] col_mid,
    input  wire logic [PIXEL_BITS-1:0] col_bot,
    input  wire logic                  in_valid,
    input  wire w3mm_pkg::w3mm_ctl_t   in_ctl,
    output logic                       out_valid,
    output w3mm_pkg::w3mm_ctl_t        out_ctl,
    output logic      [PIXEL_BITS-1:0] out_v0,
    output logic      [PIXEL_BITS-1:0] out_v1
);

    localparam int P  = PIXEL_BITS;
    localparam int SW = P + 4;
    localparam int K  = SW + 4;
    localparam int MW = K - 2;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd8) / 64'd9);

    function automatic logic [P-1:0] fmin(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [P-1:0] fmax(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [P-1:0] med3(input logic [P-1:0] a, input logic [P-1:0] b,
                                          input logic [P-1:0] c);
        return fmax(fmin(a, b), fmin(fmax(a, b), c));
    endfunction

    // {hi, mid, lo}
    function automatic logic [3*P-1:0] sort3(input logic [P-1:0] a, input logic [P-1:0] b,
                                             input logic [P-1:0] c);
        return {fmax(fmax(a, b), c), med3(a, b, c), fmin(fmin(a, b), c)};
    endfunction

    function automatic logic [P-1:0] median9(input logic [3*P-1:0] s0,
                                             input logic [3*P-1:0] s1,
                                             input logic [3*P-1:0] s2);
        logic [P-1:0] lo_max;
        logic [P-1:0] md_med;
        logic [P-1:0] hi_min;
        lo_max = fmax(fmax(s0[P-1:0], s1[P-1:0]), s2[P-1:0]);
        md_med = med3(s0[2*P-1:P], s1[2*P-1:P], s2[2*P-1:P]);
        hi_min = fmin(fmin(s0[3*P-1:2*P], s1[3*P-1:2*P]), s2[3*P-1:2*P]);
        return med3(lo_max, md_med, hi_min);
    endfunction

    // [column left..right][row top..bottom]
    logic [P-1:0] win_reg [3][3];
    logic         s3_valid_reg;
    w3mm_pkg::w3mm_ctl_t s3_ctl_reg;

    logic [3*P-1:0] srt [3];
    logic [SW-1:0]  colsum [3];

    logic         s4_valid_reg;
    w3mm_pkg::w3mm_ctl_t s4_ctl_reg;
    logic [P-1:0]  med0_reg, med1_reg;
    logic [SW-1:0] sum0_reg, sum1_reg;

    logic [SW+MW-1:0] prod0, prod1;
    logic [P-1:0]     mean0, mean1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (col_en) begin
            if (col_first) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k][0] <= col_top;
                    win_reg[k][1] <= col_mid;
                    win_reg[k][2] <= col_bot;
                end
            end else begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2][0] <= col_top;
                win_reg[2][1] <= col_mid;
                win_reg[2][2] <= col_bot;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            srt[k]    = sort3(win_reg[k][0], win_reg[k][1], win_reg[k][2]);
            colsum[k] = SW'(win_reg[k][0]) + SW'(win_reg[k][1]) + SW'(win_reg[k][2]);
        end
    end

    always_ff @(posedge aclk) begin
        med0_reg <= median9(srt[0], srt[1], srt[2]);
        med1_reg <= median9(srt[1], srt[2], srt[2]);
        sum0_reg <= colsum[0] + colsum[1] + colsum[2];
        sum1_reg <= colsum[1] + colsum[2] + colsum[2];
        s3_ctl_reg <= in_ctl;
        s4_ctl_reg <= s3_ctl_reg;
        out_ctl    <= s4_ctl_reg;
    end

    // divide by nine: multiply by rounded-up reciprocal
    assign prod0 = (SW+MW)'(sum0_reg) * (SW+MW)'(RECIP);
    assign prod1 = (SW+MW)'(sum1_reg) * (SW+MW)'(RECIP);
    assign mean0 = P'(prod0 >> K);
    assign mean1 = P'(prod1 >> K);

    always_ff @(posedge aclk) begin
        out_v0 <= (mode == w3mm_pkg::MODE_MEDIAN) ? med0_reg : mean0;
        out_v1 <= (mode == w3mm_pkg::MODE_MEDIAN) ? med1_reg : mean1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end else begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            out_valid    <= s4_valid_reg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/w3mm_outq.sv =====
`default_nettype none
module w3mm_outq #(
    parameter int PIXEL_BITS = w3mm_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    output logic                       ready,
    input  wire logic                  in_valid,
    input  wire w3mm_pkg::w3mm_ctl_t   in_ctl,
    input  wire logic [PIXEL_BITS-1:0] in_v0,
    input  wire logic [PIXEL_BITS-1:0] in_v1,
    input  wire logic [PIXEL_BITS-1:0] start_min,
    input  wire logic [PIXEL_BITS-1:0] start_max,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [PIXEL_BITS-1:0] m_pix,
    output logic      [PIXEL_BITS-1:0] m_min,
    output logic      [PIXEL_BITS-1:0] m_max,
    output logic                       m_last
);

    localparam int P   = PIXEL_BITS;
    localparam int QD  = w3mm_pkg::OUTQ_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    typedef struct packed {
        logic [P-1:0] pix;
        logic         last;
        logic [P-1:0] mn;
        logic [P-1:0] mx;
    } entry_t;

    entry_t         q [QD];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;
    logic [QCW-1:0] res_reg, res_next;
    logic [P-1:0]   run_min_reg, run_max_reg;
    logic [P-1:0]   mn0, mx0, mn1, mx1;
    logic           e0, e1, pop;
    logic [QCW-1:0] nres;
    entry_t         ent0, ent1, head;

    assign e0   = in_valid && in_ctl.emit0;
    assign e1   = in_valid && in_ctl.emit1;
    assign nres = QCW'(e0) + QCW'(e1);

    always_comb begin
        mn0 = (e0 && in_v0 < run_min_reg) ? in_v0 : run_min_reg;
        mx0 = (e0 && in_v0 > run_max_reg) ? in_v0 : run_max_reg;
        mn1 = (e1 && in_v1 < mn0) ? in_v1 : mn0;
        mx1 = (e1 && in_v1 > mx0) ? in_v1 : mx0;
        ent0 = '{pix: in_v0, last: 1'b0, mn: '0, mx: '0};
        ent1 = '{pix: in_v1, last: in_ctl.last,
                 mn: in_ctl.last ? mn1 : '0, mx: in_ctl.last ? mx1 : '0};
    end

    assign head    = q[rd_ptr_reg];
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_pix   = head.pix;
    assign m_min   = head.mn;
    assign m_max   = head.mx;
    assign m_last  = head.last;

    // every item in flight holds two slots until its results land
    assign count_next = count_reg + nres - QCW'(pop);
    assign res_next   = res_reg + (take ? QCW'(2) : '0) - QCW'(pop)
                        - (in_valid ? (QCW'(2) - nres) : '0);
    assign ready      = (res_reg <= QCW'(QD - 2));

    always_ff @(posedge aclk) begin
        if (e0) begin
            q[wr_ptr_reg] <= ent0;
        end
        if (e1) begin
            q[wr_ptr_reg + QAW'(e0)] <= ent1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            res_reg     <= '0;
            run_min_reg <= '1;
            run_max_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(nres);
            rd_ptr_reg <= rd_ptr_reg + QAW'(pop);
            count_reg  <= count_next;
            res_reg    <= res_next;
            if (in_valid) begin
                if (in_ctl.start) begin
                    run_min_reg <= start_min;
                    run_max_reg <= start_max;
                end else begin
                    run_min_reg <= mn1;
                    run_max_reg <= mx1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/window3x3_mean_median_filter.sv =====
// 3x3 mean / median filter over a raster-order greyscale stream.
// Input channel s_*: s_tuser is the command (0 pixel, 1 drain), s_tdata the pixel.
// Output channel m_*: m_tdata carries the filtered pixel and, on m_tlast, the
// frame's output minimum and maximum; elsewhere those fields are zero.
// Config cfg_wr_en/cfg_index/cfg_wdata: written only while idle by the user, not enforced.
// Output row r appears while input row r+1 streams in, one column behind;
// after the last pixel, one drain item per column flushes the last row.
// Throughput: one item per clock while s_tready is high; an item yields 0, 1 or 2
// results, and the output side moves one result per clock while m_tready is high.
// Accept to m_tvalid: line-buffer read, window update, sort/sum, divide, queue.
// Line buffers are one 1-port-read, 1-port-write memory of MAX_COLS entries
// holding both previous rows; a same-entry write on the read edge is forwarded.
// Reset clears the counters, the window and the 16-entry output queue; no
// clearing pass is needed. s_tready drops once the queue plus the items in flight
// could fill it; no result is lost.
`default_nettype none
module window3x3_mean_median_filter #(
    parameter int MAX_COLS   = w3mm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = w3mm_pkg::MAX_ROWS_DEF,
    parameter int PIXEL_BITS = w3mm_pkg::PIXEL_BITS_DEF,
    localparam int IN_W  = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * PIXEL_BITS + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [w3mm_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [w3mm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [IN_W-1:0]                 s_tdata,   // pixel_in
    input  wire logic                            s_tuser,   // cmd
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [OUT_W-1:0]                m_tdata,   // pixel_out, out_minimum, out_maximum
    output logic                                 m_tlast    // frame_last
);

    localparam int P   = PIXEL_BITS;
    localparam int AW  = $clog2(MAX_COLS);
    localparam int CEW = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);

    logic                          mode_reg;
    logic [w3mm_pkg::ROWS_W-1:0]   rows_reg;
    logic [w3mm_pkg::COLS_W-1:0]   cols_reg;
    logic [w3mm_pkg::START_W-1:0]  smin_reg, smax_reg;

    logic [RW-1:0]  row_reg, row_next;
    logic [AW-1:0]  col_reg, col_next;
    logic [RW-1:0]  rows_eff;
    logic [CEW-1:0] cols_eff;
    logic           draining, lastcol, is_drain, act, accept;

    logic           s2_valid_reg, s2_act_reg, s2_drain_reg, s2_row0_reg, s2_col0_reg;
    logic           s2_lastcol_reg;
    logic [AW-1:0]  s2_col_reg;
    logic [P-1:0]   s2_pix_reg;

    logic [2*P-1:0] lb_rd;
    logic [2*P-1:0] lb_wr;
    logic           lb_wr_en;
    logic [P-1:0]   top, mid, bot;
    logic           win_en;
    w3mm_pkg::w3mm_ctl_t s2_ctl;

    logic                f_valid;
    w3mm_pkg::w3mm_ctl_t f_ctl;
    logic [P-1:0]        f_v0, f_v1;
    logic [P-1:0]        q_pix, q_min, q_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= w3mm_pkg::MODE_MEAN;
            rows_reg <= w3mm_pkg::ROWS_W'(1);
            cols_reg <= w3mm_pkg::COLS_W'(1);
            smin_reg <= '1;
            smax_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                w3mm_pkg::REG_FILTER_MODE:   mode_reg <= cfg_wdata[0];
                w3mm_pkg::REG_IMAGE_ROWS:    rows_reg <= cfg_wdata[w3mm_pkg::ROWS_W-1:0];
                w3mm_pkg::REG_IMAGE_COLS:    cols_reg <= cfg_wdata[w3mm_pkg::COLS_W-1:0];
                w3mm_pkg::REG_START_MINIMUM: smin_reg <= cfg_wdata[w3mm_pkg::START_W-1:0];
                w3mm_pkg::REG_START_MAXIMUM: smax_reg <= cfg_wdata[w3mm_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rows_reg == '0) begin
            rows_eff = RW'(1);
        end else if (32'(rows_reg) > 32'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(rows_reg);
        end
        if (cols_reg == '0) begin
            cols_eff = CEW'(1);
        end else if (32'(cols_reg) > 32'(MAX_COLS)) begin
            cols_eff = CEW'(MAX_COLS);
        end else begin
            cols_eff = CEW'(cols_reg);
        end
    end

    assign draining = (32'(row_reg) >= 32'(rows_eff));
    assign lastcol  = ((32'(col_reg) + 32'd1) >= 32'(cols_eff));
    assign is_drain = (s_tuser == w3mm_pkg::CMD_DRAIN);
    assign act      = is_drain ? draining : !draining;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept && act) begin
            if (!lastcol) begin
                col_next = col_reg + AW'(1);
            end else begin
                col_next = '0;
                row_next = is_drain ? '0 : row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s2_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        s2_act_reg     <= act;
        s2_drain_reg   <= is_drain;
        s2_row0_reg    <= (row_reg == '0);
        s2_col0_reg    <= (col_reg == '0);
        s2_lastcol_reg <= lastcol;
        s2_col_reg     <= col_reg;
        s2_pix_reg     <= s_tdata[P-1:0];
    end

    w3mm_linebuf #(
        .DEPTH (MAX_COLS),
        .WIDTH (2 * P)
    ) u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept && act),
        .rd_addr (col_reg),
        .wr_en   (lb_wr_en),
        .wr_addr (s2_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // entry = {older row, newer row}
    assign top      = lb_rd[2*P-1:P];
    assign mid      = lb_rd[P-1:0];
    assign bot      = s2_drain_reg ? mid : s2_pix_reg;
    assign lb_wr_en = s2_valid_reg && s2_act_reg && !s2_drain_reg;
    assign lb_wr    = s2_row0_reg ? {s2_pix_reg, s2_pix_reg} : {mid, s2_pix_reg};
    assign win_en   = s2_valid_reg && s2_act_reg && (s2_drain_reg || !s2_row0_reg);

    always_comb begin
        s2_ctl.emit0 = win_en && !s2_col0_reg;
        s2_ctl.emit1 = win_en && s2_lastcol_reg;
        s2_ctl.last  = win_en && s2_drain_reg && s2_lastcol_reg;
        s2_ctl.start = s2_valid_reg && s2_act_reg && !s2_drain_reg
                       && s2_row0_reg && s2_col0_reg;
    end

    w3mm_filter #(
        .PIXEL_BITS (P)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .col_en    (win_en),
        .col_first (s2_col0_reg),
        .col_top   (top),
        .col_mid   (mid),
        .col_bot   (bot),
        .in_valid  (s2_valid_reg),
        .in_ctl    (s2_ctl),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_v0    (f_v0),
        .out_v1    (f_v1)
    );

    w3mm_outq #(
        .PIXEL_BITS (P)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (accept),
        .ready     (s_tready),
        .in_valid  (f_valid),
        .in_ctl    (f_ctl),
        .in_v0     (f_v0),
        .in_v1     (f_v1),
        .start_min (P'(smin_reg)),
        .start_max (P'(smax_reg)),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_pix     (q_pix),
        .m_min     (q_min),
        .m_max     (q_max),
        .m_last    (m_tlast)
    );

    assign m_tdata = OUT_W'({q_max, q_min, q_pix});

endmodule
`default_nettype wire

// ===== sv/w3mm_checker.sv =====
`default_nettype none
module w3mm_checker #(
    parameter int DATA_W = 32
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic              m_tlast
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("state not cleared by reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled item changed");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
        else $error("result without an item accepted five clocks earlier");

    a_drained_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !$past(s_tvalid && s_tready, 1) && !$past(s_tvalid && s_tready, 2)
         && !$past(s_tvalid && s_tready, 3) && !$past(s_tvalid && s_tready, 4)
         && !$past(s_tvalid && s_tready, 5) && $past(aresetn, 5)) |-> s_tready)
        else $error("input stalled with nothing pending");

endmodule

bind window3x3_mean_median_filter w3mm_checker #(
    .DATA_W (OUT_W)
) u_w3mm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
